// ===== src/gdds_pkg.sv =====
// gdds_pkg: shared types, constants and calendar helpers of the date day stepper
// used by gdds_step_unit and gregorian_date_day_stepper_unit
`default_nettype none

package gdds_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned REM_W   = 7;   // year mod 100
  localparam int unsigned CENT_W  = 2;   // (year / 100) mod 4
  localparam int unsigned QUOT_W  = 8;   // year / 100

  localparam int unsigned COUNT_BITS = 16;

  localparam logic [YEAR_W-1:0]  FLOOR_YEAR = YEAR_W'(1900);
  localparam logic [YEAR_W-1:0]  MAX_YEAR   = YEAR_W'(9999);
  localparam logic [REM_W-1:0]   FLOOR_REM  = REM_W'(0);    // 1900 mod 100
  localparam logic [CENT_W-1:0]  FLOOR_CENT = CENT_W'(3);   // 19 mod 4
  localparam logic [REM_W-1:0]   REM_LAST   = REM_W'(99);

  localparam logic [DAY_W-1:0]   DAY_FIRST   = DAY_W'(1);
  localparam logic [DAY_W-1:0]   DAY_MAX     = DAY_W'(31);
  localparam logic [MONTH_W-1:0] MONTH_FIRST = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_LAST  = MONTH_W'(12);
  localparam logic [MONTH_W-1:0] MONTH_FEB   = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_APR   = MONTH_W'(4);
  localparam logic [MONTH_W-1:0] MONTH_JUN   = MONTH_W'(6);
  localparam logic [MONTH_W-1:0] MONTH_SEP   = MONTH_W'(9);
  localparam logic [MONTH_W-1:0] MONTH_NOV   = MONTH_W'(11);

  // year / 100 as (year * 5243) >> 19, exact for every 14-bit year
  localparam int unsigned      RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);
  localparam int unsigned      RECIP_SHIFT = 19;
  localparam int unsigned      PROD_W      = YEAR_W + RECIP_W;
  localparam logic [QUOT_W-1:0] CENTURY    = QUOT_W'(100);

  typedef enum logic [1:0] {
    REQ_SET  = 2'd0,
    REQ_ADD  = 2'd1,
    REQ_SUB  = 2'd2,
    REQ_NONE = 2'd3
  } gdds_req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_STEP,
    ST_RESP
  } gdds_state_e;

  typedef struct packed {
    gdds_req_e            req_type;
    logic [DAY_W-1:0]     new_day;
    logic [MONTH_W-1:0]   new_month;
    logic [YEAR_W-1:0]    new_year;
    logic [CNT_W-1:0]     day_count;
  } gdds_req_t;

  typedef struct packed {
    logic [DAY_W-1:0]     day;
    logic [MONTH_W-1:0]   month;
    logic [YEAR_W-1:0]    year;
    logic                 accepted;
    logic                 at_limit;
  } gdds_rsp_t;

  // current date plus the year split that drives the leap rule
  typedef struct packed {
    logic [DAY_W-1:0]     day;
    logic [MONTH_W-1:0]   month;
    logic [YEAR_W-1:0]    year;
    logic [REM_W-1:0]     yrem;
    logic [CENT_W-1:0]    cent;
  } gdds_date_t;

  // 4/100/400 rule from year mod 4, year mod 100 and century mod 4
  function automatic logic is_leap(input logic [1:0]        lo2,
                                   input logic [REM_W-1:0]  yrem,
                                   input logic [CENT_W-1:0] cent);
    logic rem_zero;
    rem_zero = (yrem == '0);
    return ((lo2 == 2'd0) && !rem_zero) || (rem_zero && (cent == '0));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic               leap);
    logic [DAY_W-1:0] len;
    case (month)
      MONTH_FEB: len = leap ? DAY_W'(29) : DAY_W'(28);
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAY_W'(30);
      default: len = DAY_W'(31);
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== src/gdds_step_unit.sv =====
// gdds_step_unit: one-day forward or backward step of a calendar date
// depends on gdds_pkg for the date type and month length helpers
`default_nettype none

module gdds_step_unit (
  input  gdds_pkg::gdds_date_t date_i,
  input  logic                 back_i,
  output gdds_pkg::gdds_date_t date_o,
  output logic                 blocked_o
);
  import gdds_pkg::*;

  logic             leap;
  logic [DAY_W-1:0] len_cur;
  logic [DAY_W-1:0] len_prev;

  assign leap     = is_leap(date_i.year[1:0], date_i.yrem, date_i.cent);
  assign len_cur  = month_len(date_i.month, leap);
  assign len_prev = month_len(date_i.month - MONTH_W'(1), leap);

  always_comb begin
    date_o    = date_i;
    blocked_o = 1'b0;
    if (!back_i) begin
      if (date_i.day < len_cur) begin
        date_o.day = date_i.day + DAY_W'(1);
      end else if (date_i.month < MONTH_LAST) begin
        date_o.day   = DAY_FIRST;
        date_o.month = date_i.month + MONTH_W'(1);
      end else if (date_i.year < MAX_YEAR) begin
        date_o.day   = DAY_FIRST;
        date_o.month = MONTH_FIRST;
        date_o.year  = date_i.year + YEAR_W'(1);
        if (date_i.yrem == REM_LAST) begin
          date_o.yrem = '0;
          date_o.cent = date_i.cent + CENT_W'(1);
        end else begin
          date_o.yrem = date_i.yrem + REM_W'(1);
        end
      end else begin
        blocked_o = 1'b1;
      end
    end else begin
      if (date_i.day > DAY_FIRST) begin
        date_o.day = date_i.day - DAY_W'(1);
      end else if (date_i.month > MONTH_FIRST) begin
        date_o.month = date_i.month - MONTH_W'(1);
        date_o.day   = len_prev;
      end else if (date_i.year > FLOOR_YEAR) begin
        date_o.day   = DAY_MAX;
        date_o.month = MONTH_LAST;
        date_o.year  = date_i.year - YEAR_W'(1);
        if (date_i.yrem == '0) begin
          date_o.yrem = REM_LAST;
          date_o.cent = date_i.cent - CENT_W'(1);
        end else begin
          date_o.yrem = date_i.yrem - REM_W'(1);
        end
      end else begin
        blocked_o = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/gregorian_date_day_stepper_unit.sv =====
// gregorian_date_day_stepper_unit: top level of the date day stepper
// depends on gdds_pkg and gdds_step_unit
`default_nettype none

// The unit holds one calendar date, 1 Jan 1900 after reset, and serves one
// request at a time. A request transfer happens on a clock edge with start high
// and busy low; busy then stays high until the response has been shown. Every
// request ends in exactly one response: done_o high for a single cycle with the
// date after the request in rsp_o. The receiver cannot stall, so sample rsp_o
// in that cycle. Steps after the accepting edge: a set request splits the year
// by 100 with a reciprocal multiply, then checks the date and commits it, then
// responds; an add or subtract request steps the date by one day per cycle
// with the shared day step unit until day_count days are done or the date hits
// the floor or ceiling, then responds; the unused request code goes straight
// to the response. A new request can be given the
// cycle after done_o. The year is carried with its remainder mod 100 and its
// century mod 4 so the leap rule needs no division while stepping.
module gregorian_date_day_stepper_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  gdds_pkg::gdds_req_t req_i,
  output logic                done_o,
  output gdds_pkg::gdds_rsp_t rsp_o
);
  import gdds_pkg::*;

  // sequencer
  gdds_state_e state_q, state_d;

  // held date and the request in flight
  gdds_date_t          date_q, date_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;     // days left to step
  logic                back_q, back_d;   // step direction
  logic [DAY_W-1:0]    nday_q, nday_d;
  logic [MONTH_W-1:0]  nmon_q, nmon_d;
  logic [YEAR_W-1:0]   nyear_q, nyear_d;
  logic [QUOT_W-1:0]   quot_q, quot_d;   // new year / 100
  logic                acc_q, acc_d;
  logic                lim_q, lim_d;

  // shared day step unit
  gdds_date_t step_date;
  logic       step_blocked;

  gdds_step_unit u_step (
    .date_i    (date_q),
    .back_i    (back_q),
    .date_o    (step_date),
    .blocked_o (step_blocked)
  );

  // set path: year split and date check
  logic [PROD_W-1:0] prod;
  logic [YEAR_W-1:0] cent_sub;
  logic [REM_W-1:0]  new_rem;
  logic              new_leap;
  logic              new_valid;

  assign prod     = nyear_d * RECIP_100;
  assign cent_sub = YEAR_W'(quot_q) * YEAR_W'(CENTURY);
  assign new_rem  = REM_W'(nyear_q - cent_sub);
  assign new_leap = is_leap(nyear_q[1:0], new_rem, quot_q[CENT_W-1:0]);
  assign new_valid = (nday_q >= DAY_FIRST) && (nday_q <= DAY_MAX)
                  && (nmon_q >= MONTH_FIRST) && (nmon_q <= MONTH_LAST)
                  && (nyear_q >= FLOOR_YEAR) && (nyear_q <= MAX_YEAR)
                  && (nday_q <= month_len(nmon_q, new_leap));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      date_q  <= '{day: DAY_FIRST, month: MONTH_FIRST, year: FLOOR_YEAR,
                   yrem: FLOOR_REM, cent: FLOOR_CENT};
      cnt_q   <= '0;
      back_q  <= 1'b0;
      acc_q   <= 1'b0;
      lim_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      date_q  <= date_d;
      cnt_q   <= cnt_d;
      back_q  <= back_d;
      acc_q   <= acc_d;
      lim_q   <= lim_d;
    end
  end

  // request payload, no reset needed
  always_ff @(posedge clk_i) begin
    nday_q  <= nday_d;
    nmon_q  <= nmon_d;
    nyear_q <= nyear_d;
    quot_q  <= quot_d;
  end

  always_comb begin
    state_d = state_q;
    date_d  = date_q;
    cnt_d   = cnt_q;
    back_d  = back_q;
    nday_d  = nday_q;
    nmon_d  = nmon_q;
    nyear_d = nyear_q;
    quot_d  = quot_q;
    acc_d   = acc_q;
    lim_d   = lim_q;
    busy    = 1'b1;
    done_o  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          acc_d  = 1'b0;
          lim_d  = 1'b0;
          nday_d = req_i.new_day;
          nmon_d = req_i.new_month;
          nyear_d = req_i.new_year;
          cnt_d  = CNT_W'(req_i.day_count[COUNT_BITS-1:0]);
          back_d = (req_i.req_type == REQ_SUB);
          case (req_i.req_type)
            REQ_SET:          state_d = ST_DIV;
            REQ_ADD, REQ_SUB: state_d = ST_STEP;
            default:          state_d = ST_RESP;
          endcase
        end
      end
      ST_DIV: begin
        // reciprocal multiply gives year / 100
        quot_d  = prod[RECIP_SHIFT +: QUOT_W];
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (new_valid) begin
          date_d = '{day: nday_q, month: nmon_q, year: nyear_q,
                     yrem: new_rem, cent: quot_q[CENT_W-1:0]};
          acc_d  = 1'b1;
        end
        state_d = ST_RESP;
      end
      ST_STEP: begin
        if (cnt_q == '0) begin
          state_d = ST_RESP;
        end else if (step_blocked) begin
          // days remain but the date sits at the floor or ceiling
          lim_d   = 1'b1;
          state_d = ST_RESP;
        end else begin
          date_d = step_date;
          cnt_d  = cnt_q - CNT_W'(1);
        end
      end
      ST_RESP: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rsp_o = '{day: date_q.day, month: date_q.month, year: date_q.year,
                   accepted: acc_q, at_limit: lim_q};

`ifndef SYNTHESIS
  // response strobe is a single-cycle pulse
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("response strobe held longer than one cycle");

  // an accepted request keeps the unit busy in the next cycle
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request transfer did not raise busy");

  // held date never leaves the supported range
  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (date_q.day >= DAY_FIRST) && (date_q.month >= MONTH_FIRST)
    && (date_q.month <= MONTH_LAST) && (date_q.year >= FLOOR_YEAR)
    && (date_q.year <= MAX_YEAR))
    else $error("held date out of range");

  // year remainder stays within 0 to 99
  a_yrem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    date_q.yrem <= REM_LAST)
    else $error("year remainder out of range");

  // a taken set and a limit hit never share one response
  a_acc_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(rsp_o.accepted && rsp_o.at_limit))
    else $error("response flags both set");
`endif

endmodule

`default_nettype wire
